@@ src/huffman_tree_table_decoder_core_assert.svh @@
// ----------------------------------------------------------------------------
// Huffman tree table decoder assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_TABLE_DECODER_CORE_ASSERT_SVH
`define HUFFMAN_TREE_TABLE_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define HTTD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HTTD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/httd_pkg.sv @@
// ----------------------------------------------------------------------------
// Huffman tree table decoder package
// Shared widths, node and command types, and back-end state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package httd_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int IDX_W       = $clog2(MAX_NODES);
   localparam int SYM_W       = 9;
   localparam int RIGHT_W     = 11;
   localparam int BYTE_W      = 8;
   localparam int OUT_SYM_W   = 8;
   localparam int BIT_CNT_W   = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [SYM_W-1:0]   END_SYMBOL = 9'd256;
   localparam logic [RIGHT_W-1:0] LEAF_MARK  = 11'h7FF;

   typedef enum logic {
      CMD_WRITE,
      CMD_DECODE
   } cmd_kind_type;

   typedef struct packed {
      logic [SYM_W-1:0]   sym;
      logic [IDX_W-1:0]   left;
      logic [RIGHT_W-1:0] right;
   } node_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [IDX_W-1:0]   index;
      node_type           node;
      logic [BYTE_W-1:0]  data;
   } cmd_type;

   typedef struct packed {
      logic                 valid;
      cmd_type              cmd;
   } queue_head_type;

   typedef struct packed {
      logic [OUT_SYM_W-1:0] symbol;
      logic                 eom;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } back_state_type;

endpackage

@@ src/httd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module httd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/httd_front.sv @@
// ----------------------------------------------------------------------------
// Huffman tree table decoder front end
// Accepts items, sorts them into node writes and decode commands, and
// queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module httd_front
   import httd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [IDX_W-1:0]          req_node_index,
   input  logic [SYM_W-1:0]          req_node_symbol,
   input  logic [IDX_W-1:0]          req_node_left,
   input  logic signed [RIGHT_W-1:0] req_node_right,
   input  logic [BYTE_W-1:0]         req_data_byte,
   output queue_head_type            head,
   input  logic                      pop
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              accept;
   cmd_type           cmd;

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd.kind       = req_action ? CMD_DECODE : CMD_WRITE;
      cmd.index      = req_node_index;
      cmd.node.sym   = req_node_symbol;
      cmd.node.left  = req_node_left;
      cmd.node.right = req_node_right;
      cmd.data       = req_data_byte;
   end

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(accept) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

endmodule

@@ src/httd_back.sv @@
// ----------------------------------------------------------------------------
// Huffman tree table decoder back end
// Writes nodes into the table and walks the tree one bit per cycle while the output is free,
// holding one found symbol back until it is known whether it ends the byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "huffman_tree_table_decoder_core_assert.svh"

module httd_back
   import httd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  queue_head_type       head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [OUT_SYM_W-1:0] rsp_symbol,
   output logic                 rsp_end_of_message,
   output logic                 rsp_last
);

   back_state_type         state_ff, state_in;
   node_type               cur_ent_ff, cur_ent_in;
   logic [IDX_W-1:0]       cur_idx_ff, cur_idx_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   node_type               root_ff, root_in;
   logic                   finished_ff, finished_in;
   logic [BYTE_W-1:0]      byte_ff, byte_in;
   logic [BIT_CNT_W-1:0]   bit_ff, bit_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic                   pend_v_ff, pend_v_in;
   result_type             pend_ff, pend_in;
   logic                   rsp_v_ff, rsp_v_in;
   result_type             rsp_ff, rsp_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   wr_en;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [$bits(node_type)-1:0] rd_raw;
   node_type               child;
   logic                   child_leaf;
   logic                   child_end;
   logic                   out_free;
   logic                   walk_stall;
   logic                   walk_done;
   logic                   can_issue;
   logic                   bit_val;
   node_type               post_ent;
   logic [IDX_W-1:0]       post_idx;

   httd_ram #(
      .WIDTH ($bits(node_type)),
      .DEPTH (MAX_NODES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (head.cmd.index),
      .wr_data (head.cmd.node),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign child      = rd_raw;
   assign child_leaf = rd_pend_ff && (child.right == LEAF_MARK);
   assign child_end  = child_leaf && (child.sym == END_SYMBOL);
   assign out_free   = !rsp_v_ff || !rsp_stall;
   // a new leaf needs the held symbol moved out first
   assign walk_stall = child_leaf && pend_v_ff && !out_free;
   assign walk_done  = child_end || bit_ff[BIT_CNT_W-1];
   assign can_issue  = !child_end && !bit_ff[BIT_CNT_W-1];
   assign bit_val    = byte_ff[bit_ff[BIT_CNT_W-2:0]];

   always_comb begin
      if (!rd_pend_ff) begin
         post_ent = cur_ent_ff;
         post_idx = cur_idx_ff;
      end else if (child_leaf && !child_end) begin
         post_ent = root_ff;
         post_idx = '0;
      end else begin
         post_ent = child;
         post_idx = rd_idx_ff;
      end
      rd_addr = bit_val ? post_ent.right[IDX_W-1:0] : post_ent.left;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid && head.cmd.kind == CMD_DECODE && !finished_ff) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!walk_stall && walk_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_v_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cur_ent_in  = cur_ent_ff;
      cur_idx_in  = cur_idx_ff;
      rd_idx_in   = rd_idx_ff;
      root_in     = root_ff;
      finished_in = finished_ff;
      byte_in     = byte_ff;
      bit_in      = bit_ff;
      rd_pend_in  = rd_pend_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      rsp_v_in    = rsp_v_ff && rsp_stall;
      rsp_in      = rsp_ff;
      rsp_last_in = rsp_last_ff;
      pop         = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.cmd.kind == CMD_WRITE) begin
                  wr_en = 1'b1;
                  // keep the cached root and current entries coherent
                  if (head.cmd.index == '0) begin
                     root_in = head.cmd.node;
                  end
                  if (head.cmd.index == cur_idx_ff) begin
                     cur_ent_in = head.cmd.node;
                  end
               end else if (!finished_ff) begin
                  byte_in    = head.cmd.data;
                  bit_in     = '0;
                  rd_pend_in = 1'b0;
               end
            end
         end
         ST_WALK: begin
            if (!walk_stall) begin
               if (child_leaf) begin
                  if (pend_v_ff) begin
                     rsp_v_in    = 1'b1;
                     rsp_in      = pend_ff;
                     rsp_last_in = 1'b0;
                  end
                  pend_v_in      = 1'b1;
                  pend_in.symbol = child_end ? '0 : child.sym[OUT_SYM_W-1:0];
                  pend_in.eom    = child_end;
               end
               if (child_end) begin
                  finished_in = 1'b1;
               end
               cur_ent_in = post_ent;
               cur_idx_in = post_idx;
               if (can_issue) begin
                  rd_en      = 1'b1;
                  rd_idx_in  = rd_addr;
                  bit_in     = bit_ff + BIT_CNT_W'(1);
                  rd_pend_in = 1'b1;
               end else begin
                  rd_pend_in = 1'b0;
               end
            end
         end
         ST_FLUSH: begin
            if (pend_v_ff && out_free) begin
               rsp_v_in    = 1'b1;
               rsp_in      = pend_ff;
               rsp_last_in = 1'b1;
               pend_v_in   = 1'b0;
            end
         end
         default: begin
            rd_pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cur_idx_ff  <= '0;
         finished_ff <= 1'b0;
         rd_pend_ff  <= 1'b0;
         pend_v_ff   <= 1'b0;
         rsp_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cur_idx_ff  <= cur_idx_in;
         finished_ff <= finished_in;
         rd_pend_ff  <= rd_pend_in;
         pend_v_ff   <= pend_v_in;
         rsp_v_ff    <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ent_ff  <= cur_ent_in;
      rd_idx_ff   <= rd_idx_in;
      root_ff     <= root_in;
      byte_ff     <= byte_in;
      bit_ff      <= bit_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid          = rsp_v_ff;
   assign rsp_symbol         = rsp_ff.symbol;
   assign rsp_end_of_message = rsp_ff.eom;
   assign rsp_last           = rsp_last_ff;

   `HTTD_ASSERT_NOW(a_walk_not_finished, state_ff == ST_WALK, !finished_ff,
      "walking after end of message")
   `HTTD_ASSERT_NOW(a_read_only_in_walk, rd_pend_ff, state_ff == ST_WALK,
      "table read outstanding outside walk")
   `HTTD_ASSERT_NOW(a_idle_nothing_held, state_ff == ST_IDLE, !pend_v_ff,
      "symbol held back while idle")
   `HTTD_ASSERT_NOW(a_bit8_has_read, state_ff == ST_WALK && bit_ff[BIT_CNT_W-1],
      rd_pend_ff, "last bit issued without read in flight")
   `HTTD_ASSERT_NEXT(a_flush_empty_leaves, state_ff == ST_FLUSH && !pend_v_ff,
      state_ff == ST_IDLE, "flush with nothing held did not return to idle")

endmodule

@@ src/huffman_tree_table_decoder_core.sv @@
// Node write: written to the node table when the back end is idle, no result.
// Data byte: leaves the queue, then one node table read per bit plus a final step for the last
// read data, then the held symbol is released; the single read port sets the pace of one tree
// level a cycle while the output does not stall. The earliest result passes through the queue,
// the table read, the held symbol and the response register. Synchronous reset
// clears walk, end flag, queue and outputs; the node table is not cleared.
// ----------------------------------------------------------------------------
// Huffman tree table decoder
// Front end queue feeding a tree-walking back end over a node table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_tree_table_decoder_core
   import httd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [IDX_W-1:0]          req_node_index,
   input  logic [SYM_W-1:0]          req_node_symbol,
   input  logic [IDX_W-1:0]          req_node_left,
   input  logic signed [RIGHT_W-1:0] req_node_right,
   input  logic [BYTE_W-1:0]         req_data_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [OUT_SYM_W-1:0]      rsp_symbol,
   output logic                      rsp_end_of_message,
   output logic                      rsp_last
);

   queue_head_type head;
   logic           pop;

   httd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_node_index  (req_node_index),
      .req_node_symbol (req_node_symbol),
      .req_node_left   (req_node_left),
      .req_node_right  (req_node_right),
      .req_data_byte   (req_data_byte),
      .head            (head),
      .pop             (pop)
   );

   httd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_symbol         (rsp_symbol),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_last           (rsp_last)
   );

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Huffman tree table decoder testbench
// Loads code trees into the node table and feeds data bytes through the
// core, with random gaps on the request side and random stalls on the
// response side. A scoreboard walks its own copy of the tree for every
// accepted data byte and checks each symbol, end flag and last flag in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import httd_pkg::*;

   localparam int STALL_MAX      = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int ITEM_TARGET    = 160;

   typedef struct packed {
      logic [OUT_SYM_W-1:0] symbol;
      logic                 eom;
      logic                 last;
   } decoded_item_type;

   class decode_scoreboard;
      logic [SYM_W-1:0]   sym_tab[MAX_NODES];
      logic [IDX_W-1:0]   left_tab[MAX_NODES];
      logic [RIGHT_W-1:0] right_tab[MAX_NODES];
      decoded_item_type   symbols_due[$];
      logic [IDX_W-1:0]   walk_node;
      bit                 stopped;
      int                 errors;

      function new();
         walk_node = '0;
         stopped   = 1'b0;
         errors    = 0;
      endfunction

      function void note_item(input cmd_kind_type kind, input logic [IDX_W-1:0] idx,
                              input logic [SYM_W-1:0] sym, input logic [IDX_W-1:0] left,
                              input logic [RIGHT_W-1:0] right,
                              input logic [BYTE_W-1:0] data);
         int first;
         decoded_item_type hit;
         first = symbols_due.size();
         if (kind == CMD_WRITE) begin
            sym_tab[idx]   = sym;
            left_tab[idx]  = left;
            right_tab[idx] = right;
         end else if (!stopped) begin
            for (int b = 0; b < BYTE_W && !stopped; b++) begin
               // a negative right child still moves, on its low index bits
               walk_node = data[b] ? right_tab[walk_node][IDX_W-1:0] : left_tab[walk_node];
               if (right_tab[walk_node] == LEAF_MARK) begin
                  hit.last = 1'b0;
                  if (sym_tab[walk_node] == END_SYMBOL) begin
                     hit.symbol = '0;
                     hit.eom    = 1'b1;
                     stopped    = 1'b1;
                  end else begin
                     hit.symbol = sym_tab[walk_node][OUT_SYM_W-1:0];
                     hit.eom    = 1'b0;
                     walk_node  = '0;
                  end
                  symbols_due.push_back(hit);
               end
            end
            if (symbols_due.size() > first) begin
               hit = symbols_due[symbols_due.size()-1];
               hit.last = 1'b1;
               symbols_due[symbols_due.size()-1] = hit;
            end
         end
      endfunction

      function void check_result(input logic [OUT_SYM_W-1:0] symbol, input logic eom,
                                 input logic last);
         decoded_item_type want;
         if (symbols_due.size() == 0) begin
            $error("unexpected item: symbol %0d end_of_message %0b last %0b",
                   symbol, eom, last);
            errors++;
            return;
         end
         want = symbols_due.pop_front();
         if (symbol !== want.symbol) begin
            $error("symbol: expected %0d, got %0d", want.symbol, symbol);
            errors++;
         end
         if (eom !== want.eom) begin
            $error("end_of_message: expected %0b, got %0b", want.eom, eom);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            errors++;
         end
      endfunction

      function int outstanding();
         return symbols_due.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_action;
   logic [IDX_W-1:0]          req_node_index;
   logic [SYM_W-1:0]          req_node_symbol;
   logic [IDX_W-1:0]          req_node_left;
   logic signed [RIGHT_W-1:0] req_node_right;
   logic [BYTE_W-1:0]         req_data_byte;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [OUT_SYM_W-1:0]      rsp_symbol;
   logic                      rsp_end_of_message;
   logic                      rsp_last;

   decode_scoreboard sb;
   bit               node_known[MAX_NODES];
   int               known_list[$];
   bit               send_calm;
   bit               recv_calm;
   int               items_sent;
   int               idle_cycles;

   huffman_tree_table_decoder_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_node_index     (req_node_index),
      .req_node_symbol    (req_node_symbol),
      .req_node_left      (req_node_left),
      .req_node_right     (req_node_right),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_symbol         (rsp_symbol),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_last           (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic send_item(input cmd_kind_type kind, input logic [IDX_W-1:0] idx,
                            input logic [SYM_W-1:0] sym, input logic [IDX_W-1:0] left,
                            input logic [RIGHT_W-1:0] right,
                            input logic [BYTE_W-1:0] data);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, STALL_MAX);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action      = kind;
      req_node_index  = idx;
      req_node_symbol = sym;
      req_node_left   = left;
      req_node_right  = right;
      req_data_byte   = data;
      req_valid       = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_item(kind, idx, sym, left, right, data);
      items_sent++;
   endtask

   // every child of a written node must itself be written, so that no walk
   // ever lands on an entry the table has never held
   task automatic write_node(input logic [IDX_W-1:0] idx, input logic [SYM_W-1:0] sym,
                             input logic [IDX_W-1:0] left, input logic [RIGHT_W-1:0] right);
      if (!node_known[idx]) begin
         node_known[idx] = 1'b1;
         known_list.push_back(idx);
      end
      send_item(CMD_WRITE, idx, sym, left, right, BYTE_W'($urandom));
   endtask

   task automatic decode_byte(input logic [BYTE_W-1:0] data);
      send_item(CMD_DECODE, IDX_W'($urandom), SYM_W'($urandom), IDX_W'($urandom),
                RIGHT_W'($urandom), data);
   endtask

   function automatic logic [IDX_W-1:0] pick_known();
      return IDX_W'(known_list[$urandom_range(0, known_list.size() - 1)]);
   endfunction

   // any leaf symbol but the end marker, wide ones included
   function automatic logic [SYM_W-1:0] leaf_symbol();
      int s;
      s = $urandom_range(0, 510);
      return (s >= int'(END_SYMBOL)) ? SYM_W'(s + 1) : SYM_W'(s);
   endfunction

   // leaves first, then joins pairs of subtrees; the final join lands on root
   task automatic build_tree();
      int subtrees[$];
      int pos;
      int a;
      int b;
      int idx;
      logic [RIGHT_W-1:0] right;
      repeat ($urandom_range(2, 6)) begin
         idx = $urandom_range(1, MAX_NODES - 2);
         write_node(IDX_W'(idx), leaf_symbol(), pick_known(), LEAF_MARK);
         subtrees.push_back(idx);
      end
      while (subtrees.size() > 1) begin
         pos = $urandom_range(0, subtrees.size() - 1);
         a = subtrees[pos];
         subtrees.delete(pos);
         pos = $urandom_range(0, subtrees.size() - 1);
         b = subtrees[pos];
         subtrees.delete(pos);
         idx = (subtrees.size() == 0) ? 0 : $urandom_range(1, MAX_NODES - 2);
         right = $urandom_range(0, 1) ? {1'b1, IDX_W'(b)} : {1'b0, IDX_W'(b)};
         write_node(IDX_W'(idx), SYM_W'($urandom), IDX_W'(a), right);
         subtrees.push_back(idx);
      end
   endtask

   task automatic noise_write();
      logic [IDX_W-1:0]   child;
      logic [RIGHT_W-1:0] right;
      logic [SYM_W-1:0]   sym;
      child = pick_known();
      case ($urandom_range(0, 2))
         0: right = LEAF_MARK;
         1: right = {1'b0, child};
         default: right = {1'b1, child};
      endcase
      sym = SYM_W'($urandom);
      // the end marker is kept back for the closing sequence
      if (right == LEAF_MARK && sym == END_SYMBOL)
         sym = SYM_W'(255);
      write_node(IDX_W'($urandom), sym, pick_known(), right);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.outstanding() > 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("huffman_tree_table_decoder_core test failed");
         $finish;
      end
   end

   initial begin
      int hold;
      rsp_stall = 1'b0;
      recv_calm = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0)
            recv_calm = !recv_calm;
         hold = recv_calm ? 0 : $urandom_range(0, STALL_MAX);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_result(rsp_symbol, rsp_end_of_message, rsp_last);
         @(negedge clock);
      end
   end

   initial begin
      logic [IDX_W-1:0] cur;
      logic [IDX_W-1:0] end_leaf;
      logic [IDX_W-1:0] sym_leaf;
      bit               paused;
      sb              = new();
      idle_cycles     = 0;
      req_valid       = 1'b0;
      req_action      = CMD_WRITE;
      req_node_index  = '0;
      req_node_symbol = '0;
      req_node_left   = '0;
      req_node_right  = '0;
      req_data_byte   = '0;
      send_calm       = 1'b0;
      items_sent      = 0;
      paused          = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // root loops to itself: bytes walk but never reach a leaf
      write_node(10'd1023, 9'd511, 10'd1023, LEAF_MARK);
      write_node(10'd0, 9'd0, 10'd0, 11'd0);
      decode_byte(8'h00);
      decode_byte(8'hFF);
      // two leaves under root: a leaf on every bit, one wide symbol
      write_node(10'd1, 9'd65, 10'd0, LEAF_MARK);
      write_node(10'd2, 9'd257, 10'd0, LEAF_MARK);
      write_node(10'd0, 9'd256, 10'd1, 11'd2);
      decode_byte(8'h00);
      decode_byte(8'hFF);
      decode_byte(8'hA5);
      // inner node with a negative right child (low bits give node 2)
      write_node(10'd3, 9'd5, 10'd1, 11'h402);
      write_node(10'd0, 9'd0, 10'd3, 11'd1023);
      decode_byte(8'h00);
      decode_byte(8'h55);
      decode_byte(8'hC3);
      // root marked as a leaf is never tested itself; its -1 child is 1023
      write_node(10'd0, 9'd300, 10'd1, LEAF_MARK);
      decode_byte(8'hFF);
      decode_byte(8'h0F);
      write_node(10'd1022, 9'd200, 10'd1022, LEAF_MARK);
      write_node(10'd0, 9'd0, 10'd1022, 11'h7FE);
      decode_byte(8'h3C);

      while (items_sent < ITEM_TARGET) begin
         send_calm = ($urandom_range(0, 3) == 0);
         if (!paused && items_sent > ITEM_TARGET / 2) begin
            paused = 1'b1;
            wait_drained();
         end
         if ($urandom_range(0, 9) < 7) begin
            build_tree();
            repeat ($urandom_range(2, 6)) decode_byte(BYTE_W'($urandom));
         end else begin
            repeat ($urandom_range(1, 3)) noise_write();
            repeat ($urandom_range(1, 2)) decode_byte(BYTE_W'($urandom));
         end
      end

      // closing sequence: steer the walk from wherever it stands to the end
      // marker, then check that later bytes are dropped
      send_calm = 1'b0;
      cur       = sb.walk_node;
      end_leaf  = (cur == 10'd1020) ? 10'd1018 : 10'd1020;
      sym_leaf  = (cur == 10'd1021) ? 10'd1019 : 10'd1021;
      write_node(sym_leaf, 9'd66, sym_leaf, LEAF_MARK);
      write_node(end_leaf, END_SYMBOL, sym_leaf, LEAF_MARK);
      write_node(cur, 9'd0, sym_leaf, {1'b0, sym_leaf});
      write_node(10'd0, 9'd0, sym_leaf, {1'b0, end_leaf});
      decode_byte(8'h00);
      decode_byte(8'h06);
      decode_byte(8'hFF);
      noise_write();
      decode_byte(8'h00);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("huffman_tree_table_decoder_core test passed");
      else
         $display("huffman_tree_table_decoder_core test failed");
      $finish;
   end

endmodule
